@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ src/hcd_pkg.sv @@
// ---------------------------------------------------------------------------
// hcd_pkg
// types, codes and byte classifiers for the chunked body decoder
// ---------------------------------------------------------------------------
`default_nettype none

package hcd_pkg;

  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned SIZE_BITS      = 32;
  localparam int unsigned REPORT_BITS    = 32;
  localparam int unsigned DIGIT_BITS     = 4;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;

  // largest magnitude that still takes one more hex digit without overflow
  localparam logic [SIZE_BITS-1:0] ACCUM_LIMIT = {{DIGIT_BITS{1'b0}}, {(SIZE_BITS-DIGIT_BITS){1'b1}}};

  typedef enum logic [1:0] {
    ST_TERM  = 2'd0,
    ST_ENDED = 2'd1,
    ST_TRUNC = 2'd2,
    ST_BAD   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    SZ_NONE   = 3'd0,
    SZ_WS     = 3'd1,
    SZ_SIGN   = 3'd2,
    SZ_ZERO   = 3'd3,
    SZ_XPFX   = 3'd4,
    SZ_DIGITS = 3'd5
  } size_flag_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]             out_byte;
    logic                   out_valid;
    logic                   done_res;
    logic [1:0]             status;
    logic [REPORT_BITS-1:0] out_count;
  } out_beat_t;

  // size field update from one byte
  typedef struct packed {
    size_flag_e           flags;
    logic                 neg;
    logic [SIZE_BITS-1:0] accum;
    logic                 goto_lf;
    logic                 stop;
    status_e              stop_st;
    logic [SIZE_BITS-1:0] chunk;
  } size_upd_t;

  // per-item result from the decode stage
  typedef struct packed {
    logic      has_res;
    out_beat_t beat;
  } step_res_t;

  typedef struct packed {
    logic                  ok;
    logic [DIGIT_BITS-1:0] val;
  } hex_t;

  function automatic hex_t hex_value(input logic [7:0] b);
    hex_t h;
    h.ok  = 1'b1;
    h.val = '0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.val = DIGIT_BITS'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.val = DIGIT_BITS'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.val = DIGIT_BITS'(b - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SP) || (b >= CH_TAB && b <= CH_CR);
  endfunction

endpackage

`default_nettype wire

@@ src/hcd_if.sv @@
// ---------------------------------------------------------------------------
// hcd stream interfaces
// valid/ready channels for body bytes in and decoded results out
// ---------------------------------------------------------------------------
`default_nettype none

interface hcd_in_if;
  logic               valid;
  logic               ready;
  hcd_pkg::in_beat_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface hcd_out_if;
  logic               valid;
  logic               ready;
  hcd_pkg::out_beat_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/hcd_size_parse.sv @@
// ---------------------------------------------------------------------------
// hcd_size_parse
// one-byte step of the hex chunk size field (strtol base 16 style)
// ---------------------------------------------------------------------------
`default_nettype none

module hcd_size_parse (
  input  hcd_pkg::size_flag_e                 flags_i,
  input  logic                                neg_i,
  input  logic [hcd_pkg::SIZE_BITS-1:0]       accum_i,
  input  logic [7:0]                          byte_i,
  output hcd_pkg::size_upd_t                  upd_o
);
  import hcd_pkg::*;

  hex_t hx;

  always_comb begin
    hx            = hex_value(byte_i);
    upd_o.flags   = flags_i;
    upd_o.neg     = neg_i;
    upd_o.accum   = accum_i;
    upd_o.goto_lf = 1'b0;
    upd_o.stop    = 1'b0;
    upd_o.stop_st = ST_TERM;
    upd_o.chunk   = neg_i ? (SIZE_BITS'(0) - accum_i) : accum_i;

    unique case (flags_i) inside
      SZ_NONE, SZ_WS: begin
        if (is_space(byte_i)) begin
          upd_o.flags = SZ_WS;
        end else if (byte_i == CH_PLUS || byte_i == CH_MINUS) begin
          upd_o.neg   = (byte_i == CH_MINUS);
          upd_o.flags = SZ_SIGN;
        end else if (hx.ok) begin
          upd_o.accum = SIZE_BITS'(hx.val);
          upd_o.flags = (hx.val == '0) ? SZ_ZERO : SZ_DIGITS;
        end else begin
          upd_o.stop = 1'b1;
        end
      end
      SZ_SIGN: begin
        if (hx.ok) begin
          upd_o.accum = SIZE_BITS'(hx.val);
          upd_o.flags = (hx.val == '0) ? SZ_ZERO : SZ_DIGITS;
        end else begin
          upd_o.stop = 1'b1;
        end
      end
      SZ_ZERO: begin
        if (byte_i == CH_X_LO || byte_i == CH_X_UP) begin
          upd_o.flags = SZ_XPFX;
        end else if (hx.ok) begin
          upd_o.accum = SIZE_BITS'(hx.val);
          upd_o.flags = SZ_DIGITS;
        end else begin
          upd_o.stop = 1'b1;
        end
      end
      SZ_XPFX: begin
        if (hx.ok) begin
          upd_o.accum = SIZE_BITS'(hx.val);
          upd_o.flags = SZ_DIGITS;
        end else begin
          upd_o.stop = 1'b1;
        end
      end
      default: begin
        if (hx.ok) begin
          // saturate rather than wrap
          if (accum_i > ACCUM_LIMIT) begin
            upd_o.accum = '1;
          end else begin
            upd_o.accum = {accum_i[SIZE_BITS-DIGIT_BITS-1:0], hx.val};
          end
        end else if (accum_i == '0) begin
          // negated zero is still zero
          upd_o.stop = 1'b1;
        end else if (byte_i == CH_CR) begin
          upd_o.goto_lf = 1'b1;
        end else begin
          upd_o.stop    = 1'b1;
          upd_o.stop_st = ST_BAD;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

@@ src/hcd_decode.sv @@
// ---------------------------------------------------------------------------
// hcd_decode
// chunk framing state, payload counting and end-of-body report
// ---------------------------------------------------------------------------
`default_nettype none

module hcd_decode #(
  parameter int unsigned CountBits = hcd_pkg::COUNT_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  hcd_pkg::in_beat_t   beat_i,
  output hcd_pkg::step_res_t  res_o
);
  import hcd_pkg::*;

  typedef enum logic [2:0] {
    PH_SIZE     = 3'd0,
    PH_SIZE_LF  = 3'd1,
    PH_PAYLOAD  = 3'd2,
    PH_TRAIL_CR = 3'd3,
    PH_TRAIL_LF = 3'd4,
    PH_STOPPED  = 3'd5
  } phase_e;

  phase_e               phase_q, phase_d;
  size_flag_e           flags_q, flags_d;
  logic                 neg_q, neg_d;
  logic [SIZE_BITS-1:0] accum_q, accum_d;
  logic [SIZE_BITS-1:0] left_q, left_d;
  logic [CountBits-1:0] total_q, total_d;
  status_e              end_st_q, end_st_d;

  size_upd_t              upd;
  logic                   pay;
  status_e                fin_st;
  logic [REPORT_BITS-1:0] cnt_rep;

  hcd_size_parse u_size (
    .flags_i (flags_q),
    .neg_i   (neg_q),
    .accum_i (accum_q),
    .byte_i  (beat_i.in_byte),
    .upd_o   (upd)
  );

  generate
    if (CountBits >= REPORT_BITS) begin : g_cnt_wide
      assign cnt_rep = total_d[REPORT_BITS-1:0];
    end else begin : g_cnt_narrow
      assign cnt_rep = {{(REPORT_BITS-CountBits){1'b0}}, total_d};
    end
  endgenerate

  always_comb begin
    phase_d  = phase_q;
    flags_d  = flags_q;
    neg_d    = neg_q;
    accum_d  = accum_q;
    left_d   = left_q;
    total_d  = total_q;
    end_st_d = end_st_q;
    pay      = 1'b0;

    unique case (phase_q)
      PH_SIZE: begin
        flags_d = upd.flags;
        neg_d   = upd.neg;
        accum_d = upd.accum;
        if (upd.stop) begin
          phase_d  = PH_STOPPED;
          end_st_d = upd.stop_st;
        end else if (upd.goto_lf) begin
          left_d  = upd.chunk;
          phase_d = PH_SIZE_LF;
        end
      end
      PH_SIZE_LF: begin
        if (beat_i.in_byte == CH_LF) begin
          phase_d = (left_q != '0) ? PH_PAYLOAD : PH_TRAIL_CR;
        end else begin
          phase_d  = PH_STOPPED;
          end_st_d = ST_BAD;
        end
      end
      PH_PAYLOAD: begin
        pay    = 1'b1;
        left_d = left_q - SIZE_BITS'(1);
        if (total_q != '1) begin
          total_d = total_q + CountBits'(1);
        end
        if (left_q == SIZE_BITS'(1)) begin
          phase_d = PH_TRAIL_CR;
        end
      end
      PH_TRAIL_CR: begin
        if (beat_i.in_byte == CH_CR) begin
          phase_d = PH_TRAIL_LF;
        end else begin
          phase_d  = PH_STOPPED;
          end_st_d = ST_TRUNC;
        end
      end
      PH_TRAIL_LF: begin
        if (beat_i.in_byte == CH_LF) begin
          phase_d = PH_SIZE;
          flags_d = SZ_NONE;
          neg_d   = 1'b0;
          accum_d = '0;
        end else begin
          phase_d  = PH_STOPPED;
          end_st_d = ST_TRUNC;
        end
      end
      default: begin
      end
    endcase

    // status as seen after this byte
    unique case (phase_d)
      PH_STOPPED: fin_st = end_st_d;
      PH_SIZE: begin
        if (flags_d == SZ_NONE) begin
          fin_st = ST_ENDED;
        end else if (flags_d == SZ_DIGITS && accum_d != '0) begin
          fin_st = ST_BAD;
        end else begin
          fin_st = ST_TERM;
        end
      end
      PH_SIZE_LF: fin_st = ST_BAD;
      default:    fin_st = ST_TRUNC;
    endcase

    res_o.has_res        = pay | beat_i.last_byte;
    res_o.beat.out_byte  = pay ? beat_i.in_byte : 8'h00;
    res_o.beat.out_valid = pay;
    res_o.beat.done_res  = beat_i.last_byte;
    res_o.beat.status    = beat_i.last_byte ? fin_st : ST_TERM;
    res_o.beat.out_count = (beat_i.last_byte && fin_st != ST_BAD) ? cnt_rep : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SIZE;
      flags_q  <= SZ_NONE;
      neg_q    <= 1'b0;
      accum_q  <= '0;
      left_q   <= '0;
      total_q  <= '0;
      end_st_q <= ST_TERM;
    end else if (step_i) begin
      if (beat_i.last_byte) begin
        // body finished: back to the start for the next one
        phase_q  <= PH_SIZE;
        flags_q  <= SZ_NONE;
        neg_q    <= 1'b0;
        accum_q  <= '0;
        left_q   <= '0;
        total_q  <= '0;
        end_st_q <= ST_TERM;
      end else begin
        phase_q  <= phase_d;
        flags_q  <= flags_d;
        neg_q    <= neg_d;
        accum_q  <= accum_d;
        left_q   <= left_d;
        total_q  <= total_d;
        end_st_q <= end_st_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ src/http_chunked_decoder.sv @@
// ---------------------------------------------------------------------------
// http_chunked_decoder
// decodes a chunked transfer body byte by byte, passes payload bytes on and
// reports status and delivered byte count on the last byte of the body
// ---------------------------------------------------------------------------
//
//   channel | dir | beat payload                                 | accepted when
//   --------+-----+----------------------------------------------+----------------
//   in_i    | in  | in_byte, last_byte                           | valid && ready
//   out_o   | out | out_byte, out_valid, done_res, status, count | valid && ready
//
// one body byte per cycle sustained while the output is not held; a result beat
// is decoded from the input register into the output register
// a byte that yields no result (framing, size field, stopped) leaves no beat
// reset returns the decoder to the start of a size field with a zero count
// when the output register is held, the input register holds its byte only if
// that byte has a result to deliver, and ready drops only then
//
`default_nettype none

module http_chunked_decoder #(
  parameter int unsigned CountBits = hcd_pkg::COUNT_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hcd_in_if.sink       in_i,
  hcd_out_if.source    out_o
);
  import hcd_pkg::*;

  // input register
  logic      s1_vld_q;
  in_beat_t  s1_beat_q;

  // output register
  logic      o_vld_q;
  out_beat_t o_beat_q;

  step_res_t res;
  logic      out_free;
  logic      s1_adv;

  // the held byte moves on unless it has a result and the output is blocked
  assign out_free   = !o_vld_q || out_o.ready;
  assign s1_adv     = s1_vld_q && (!res.has_res || out_free);
  assign in_i.ready = !s1_vld_q || s1_adv;

  assign out_o.valid = o_vld_q;
  assign out_o.data  = o_beat_q;

  hcd_decode #(
    .CountBits (CountBits)
  ) u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .beat_i (s1_beat_q),
    .res_o  (res)
  );

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else begin
      if (in_i.ready) begin
        s1_vld_q <= in_i.valid;
      end
      if (out_free) begin
        o_vld_q <= s1_adv && res.has_res;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_beat_q <= in_i.data;
    end
    if (out_free && s1_adv && res.has_res) begin
      o_beat_q <= res.beat;
    end
  end

endmodule

`default_nettype wire

@@ src/hcd_checker.sv @@
// ---------------------------------------------------------------------------
// hcd_checker
// port-level checks on the chunked body decoder, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hcd_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  hcd_pkg::out_beat_t out_data_i
);
  import hcd_pkg::*;

  // a held result beat keeps its contents
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i))

  // every result beat carries a payload byte or the end report
  `ASSERT_IMPLY(a_res_nonempty, clk_i, rst_ni, out_valid_i, out_data_i.out_valid || out_data_i.done_res)

  // status and count are zero on beats that are not the end report
  `ASSERT_IMPLY(a_report_only_at_end, clk_i, rst_ni, out_valid_i && !out_data_i.done_res, out_data_i.status == ST_TERM && out_data_i.out_count == '0)

  // bad format reports no bytes
  `ASSERT_IMPLY(a_bad_zero_count, clk_i, rst_ni, out_valid_i && out_data_i.done_res && out_data_i.status == ST_BAD, out_data_i.out_count == '0)

  // with the output register free or draining, an offered byte is taken
  `ASSERT_IMPLY(a_in_not_stuck, clk_i, rst_ni, in_valid_i && (!out_valid_i || out_ready_i), in_ready_i)

endmodule

bind http_chunked_decoder hcd_checker u_hcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);

`default_nettype wire
